### rtl/rbb_pkg.sv
// Shared widths, register codes and control structs for the row box blur.
package rbb_pkg;

  localparam int PIX_W          = 8;
  localparam int NUM_LANES      = 3;
  localparam int RADIUS_W       = 5;
  localparam int WIDTH_W        = 13;
  localparam int COL_W          = 12;  // column counter, wraps at 4096
  localparam int APB_DW         = 32;
  localparam int APB_AW         = 3;
  localparam int QB_IW          = $clog2(PIX_W);
  localparam int DEF_MAX_RADIUS = 31;
  localparam int DEF_MAX_WIDTH  = 4096;

  localparam logic [RADIUS_W-1:0] RADIUS_RST    = 5'd1;
  localparam logic [WIDTH_W-1:0]  ROW_WIDTH_RST = 13'd64;

  typedef enum logic [0:0] {
    REG_RADIUS    = 1'b0,
    REG_ROW_WIDTH = 1'b1
  } reg_idx_t;

  // sequencer -> lanes
  typedef struct packed {
    logic             wr;
    logic             first_wr;
    logic             tap_vld;
    logic             tap_first;
    logic             acc_clr;
    logic             div_step;
    logic [QB_IW-1:0] div_bit;
  } lane_ctl_t;

  // sequencer -> merge stage
  typedef struct packed {
    logic load;
    logic row_end;
  } res_ctl_t;

endpackage

### rtl/row_box_blur_edge_clamp_top.sv
// Top level of the row box blur with replicated row edges.
//
//  channel  handshake             payload
//  -------  --------------------  ---------------------------------------------
//  cfg      psel/penable/pready   paddr, pwdata -> radius (0x0), row_width (0x4)
//  in       in_valid/in_ready     in_blue_in, in_green_in, in_red_in
//  out      out_valid/out_ready   out_blue_out, out_green_out, out_red_out,
//                                 out_row_end
//
// Each result that an input releases is formed in order from 2r+1 taps
// (r the effective radius) through the single read port of each lane's
// window store, a flush for the last read, eight divide steps and a hand-over
// to the output register.
// Reset (synchronous, rst_n low) clears the sequencer, the column count and
// the output valid, and sets radius to 1 and row_width to 64. The window
// store is not cleared: only columns already written in the current row are read.
// out_ready low holds the output register; the next result is finished and
// waits, and in_ready stays low until the last result of an item is handed over.
module row_box_blur_edge_clamp_top #(
  parameter int MAX_RADIUS = rbb_pkg::DEF_MAX_RADIUS,
  parameter int MAX_WIDTH  = rbb_pkg::DEF_MAX_WIDTH
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // configuration
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [rbb_pkg::APB_AW-1:0]  paddr,
  input  logic [rbb_pkg::APB_DW-1:0]  pwdata,
  output logic [rbb_pkg::APB_DW-1:0]  prdata,
  output logic                        pready,
  // pixels in
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [rbb_pkg::PIX_W-1:0]   in_blue_in,
  input  logic [rbb_pkg::PIX_W-1:0]   in_green_in,
  input  logic [rbb_pkg::PIX_W-1:0]   in_red_in,
  // averages out
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [rbb_pkg::PIX_W-1:0]   out_blue_out,
  output logic [rbb_pkg::PIX_W-1:0]   out_green_out,
  output logic [rbb_pkg::PIX_W-1:0]   out_red_out,
  output logic                        out_row_end
);
  import rbb_pkg::*;

  // Window store depth is the next power of two above 2*MAX_RADIUS+1, so the
  // column's low bits address it directly.
  localparam int NMAX  = 2 * MAX_RADIUS + 1;
  localparam int AW    = $clog2(NMAX + 1);
  // 2*sum+n peaks just below 2^(PIX_W+1) * n
  localparam int ACC_W = $clog2(((1 << (PIX_W + 1)) - 1) * NMAX + 1);
  localparam int DW    = $clog2(2 * NMAX + 1);

  logic [RADIUS_W-1:0] radius_r, radius_nxt;
  logic [WIDTH_W-1:0]  row_width_r, row_width_nxt;
  reg_idx_t            reg_idx;
  logic                cfg_wr;

  lane_ctl_t                       lane_ctl;
  res_ctl_t                        res;
  logic [AW-1:0]                   mem_addr;
  logic [DW-1:0]                   dvs;
  logic                            merge_free;
  logic [NUM_LANES-1:0][PIX_W-1:0] pix;
  logic [NUM_LANES-1:0][PIX_W-1:0] lane_q;
  logic [NUM_LANES-1:0][PIX_W-1:0] out_pix;

  // ---------------------------------------------------------------- registers
  assign pready  = 1'b1;
  assign reg_idx = reg_idx_t'(paddr[APB_AW-1:2]);
  assign cfg_wr  = psel && penable && pwrite;

  always_comb begin
    radius_nxt    = radius_r;
    row_width_nxt = row_width_r;
    if (cfg_wr) begin
      case (reg_idx)
        REG_RADIUS:    radius_nxt    = pwdata[RADIUS_W-1:0];
        REG_ROW_WIDTH: row_width_nxt = pwdata[WIDTH_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r    <= RADIUS_RST;
      row_width_r <= ROW_WIDTH_RST;
    end else begin
      radius_r    <= radius_nxt;
      row_width_r <= row_width_nxt;
    end
  end

  always_comb begin
    case (reg_idx)
      REG_RADIUS:    prdata = APB_DW'(radius_r);
      REG_ROW_WIDTH: prdata = APB_DW'(row_width_r);
      default:       prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------- sequencer
  rbb_ctrl #(
    .MAX_RADIUS (MAX_RADIUS),
    .MAX_WIDTH  (MAX_WIDTH),
    .AW         (AW),
    .DW         (DW)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .radius     (radius_r),
    .row_width  (row_width_r),
    .merge_free (merge_free),
    .ctl        (lane_ctl),
    .mem_addr   (mem_addr),
    .dvs        (dvs),
    .res        (res)
  );

  // ---------------------------------------------------------------- lanes
  // lane 0 blue, lane 1 green, lane 2 red
  assign pix[0] = in_blue_in;
  assign pix[1] = in_green_in;
  assign pix[2] = in_red_in;

  for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
    rbb_lane #(
      .AW    (AW),
      .ACC_W (ACC_W),
      .DW    (DW)
    ) u_lane (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctl      (lane_ctl),
      .mem_addr (mem_addr),
      .pix_in   (pix[g]),
      .dvs      (dvs),
      .quo      (lane_q[g])
    );
  end

  // ---------------------------------------------------------------- merge
  rbb_merge u_merge (
    .clk         (clk),
    .rst_n       (rst_n),
    .res         (res),
    .lane_q      (lane_q),
    .free        (merge_free),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_pix     (out_pix),
    .out_row_end (out_row_end)
  );

  assign out_blue_out  = out_pix[0];
  assign out_green_out = out_pix[1];
  assign out_red_out   = out_pix[2];

  // ---------------------------------------------------------------- checks
  // a result is only loaded when the output register is free or draining
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    res.load |-> (!out_valid || out_ready))
    else $error("result loaded over an untaken output");

  // no lane activity while the block offers to take a pixel
  a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !(lane_ctl.tap_vld || lane_ctl.div_step || res.load))
    else $error("lane busy while input ready");

  // a new window sum never starts on top of taps still in flight
  a_fresh_sum: assert property (@(posedge clk) disable iff (!rst_n)
    lane_ctl.acc_clr |-> !$past(lane_ctl.tap_vld))
    else $error("accumulator cleared during a tap run");

endmodule

### rtl/rbb_lane.sv
// One colour channel: window store, first pixel, tap accumulator and bit-serial divider.
module rbb_lane #(
  parameter int AW    = 6,
  parameter int ACC_W = 15,
  parameter int DW    = 7
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  rbb_pkg::lane_ctl_t        ctl,
  input  logic [AW-1:0]             mem_addr,
  input  logic [rbb_pkg::PIX_W-1:0] pix_in,
  input  logic [DW-1:0]             dvs,
  output logic [rbb_pkg::PIX_W-1:0] quo
);
  import rbb_pkg::*;

  localparam int DEPTH = 1 << AW;

  logic [PIX_W-1:0] mem [DEPTH];
  logic [PIX_W-1:0] rd_q_r;
  logic [PIX_W-1:0] first_r;
  logic             tap_vld_r;
  logic             tap_first_r;
  logic [ACC_W-1:0] acc_r, acc_nxt;
  logic [PIX_W-1:0] quo_r, quo_nxt;
  logic [ACC_W-1:0] trial;
  logic [PIX_W-1:0] tap;

  always_ff @(posedge clk) begin
    if (ctl.wr) begin
      mem[mem_addr] <= pix_in;
    end
    rd_q_r <= mem[mem_addr];
  end

  always_ff @(posedge clk) begin
    if (ctl.first_wr) begin
      first_r <= pix_in;
    end
  end

  // read data lands in the cycle after the address
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tap_vld_r   <= 1'b0;
      tap_first_r <= 1'b0;
    end else begin
      tap_vld_r   <= ctl.tap_vld;
      tap_first_r <= ctl.tap_first;
    end
  end

  assign tap   = tap_first_r ? first_r : rd_q_r;
  assign trial = ACC_W'(dvs) << ctl.div_bit;

  // acc starts at n and gathers 2*pixel, so it ends holding 2*sum+n
  always_comb begin
    acc_nxt = acc_r;
    quo_nxt = quo_r;
    if (ctl.acc_clr) begin
      acc_nxt = ACC_W'(dvs >> 1);
      quo_nxt = '0;
    end else if (tap_vld_r) begin
      acc_nxt = acc_r + ACC_W'({tap, 1'b0});
    end else if (ctl.div_step && (acc_r >= trial)) begin
      acc_nxt              = acc_r - trial;
      quo_nxt[ctl.div_bit] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    quo_r <= quo_nxt;
  end

  assign quo = quo_r;

endmodule

### rtl/rbb_ctrl.sv
// Sequencer: column tracking, result positions, tap addresses and divide steps.
module rbb_ctrl #(
  parameter int MAX_RADIUS = 31,
  parameter int MAX_WIDTH  = 4096,
  parameter int AW         = 6,
  parameter int DW         = 7
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [rbb_pkg::RADIUS_W-1:0] radius,
  input  logic [rbb_pkg::WIDTH_W-1:0]  row_width,
  input  logic                         merge_free,
  output rbb_pkg::lane_ctl_t           ctl,
  output logic [AW-1:0]                mem_addr,
  output logic [DW-1:0]                dvs,
  output rbb_pkg::res_ctl_t            res
);
  import rbb_pkg::*;

  localparam int RW    = $clog2(MAX_RADIUS + 1);
  localparam int KW    = RW + 1;
  localparam int MX    = (COL_W > RW) ? COL_W : RW;
  localparam int SW    = MX + 3;
  localparam int CMP_W = (COL_W + 1 > WIDTH_W) ? COL_W + 1 : WIDTH_W;
  localparam int RC_W  = (RW > RADIUS_W) ? RW : RADIUS_W;
  localparam int AXW   = (COL_W > AW) ? COL_W : AW;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_ACC   = 5'b00010,
    S_FLUSH = 5'b00100,
    S_DIV   = 5'b01000,
    S_OUT   = 5'b10000
  } state_t;

  state_t           st_r, st_nxt;
  logic [COL_W-1:0] col_r, col_nxt;
  logic [COL_W-1:0] p_r, p_nxt;
  logic [COL_W-1:0] p_last_r, p_last_nxt;
  logic [COL_W-1:0] c_last_r, c_last_nxt;
  logic             end_row_r, end_row_nxt;
  logic [RW-1:0]    r_r, r_nxt;
  logic [KW-1:0]    k_r, k_nxt;
  logic [QB_IW-1:0] bit_r, bit_nxt;

  logic [RW-1:0]    r_eff;
  logic [CMP_W-1:0] w_eff;
  logic             row_end_in;
  logic             c_ge_r;
  logic             has_emit;
  logic [COL_W-1:0] c_minus_r;
  logic [COL_W-1:0] p_first;
  logic [COL_W-1:0] p_last;
  logic signed [SW-1:0] q;
  logic             q_over;
  logic [COL_W-1:0] tap_col;
  logic [AXW-1:0]   tap_ext;
  logic [AXW-1:0]   wr_ext;
  logic             last_pos;

  // effective register values
  always_comb begin
    if (RC_W'(radius) > RC_W'(MAX_RADIUS)) begin
      r_eff = RW'(MAX_RADIUS);
    end else begin
      r_eff = RW'(radius);
    end
    if (row_width == '0) begin
      w_eff = CMP_W'(1);
    end else if (CMP_W'(row_width) > CMP_W'(MAX_WIDTH)) begin
      w_eff = CMP_W'(MAX_WIDTH);
    end else begin
      w_eff = CMP_W'(row_width);
    end
  end

  assign row_end_in = (CMP_W'(col_r) + CMP_W'(1)) >= w_eff;
  assign c_ge_r     = SW'(col_r) >= SW'(r_eff);
  assign has_emit   = row_end_in || c_ge_r;
  assign c_minus_r  = col_r - COL_W'(r_eff);
  assign p_first    = (row_end_in && !c_ge_r) ? '0 : c_minus_r;
  assign p_last     = row_end_in ? col_r : c_minus_r;

  // tap column p+k-r, clamped to the row
  assign q       = $signed(SW'(p_r)) + $signed(SW'(k_r)) - $signed(SW'(r_r));
  assign q_over  = q > $signed(SW'(c_last_r));
  assign tap_col = q_over ? c_last_r : q[COL_W-1:0];
  assign tap_ext = AXW'(tap_col);
  assign wr_ext  = AXW'(col_r);

  assign mem_addr = (st_r == S_IDLE) ? wr_ext[AW-1:0] : tap_ext[AW-1:0];
  assign dvs      = DW'({r_r, 2'b10});
  assign last_pos = (p_r == p_last_r);

  always_comb begin
    st_nxt      = st_r;
    col_nxt     = col_r;
    p_nxt       = p_r;
    p_last_nxt  = p_last_r;
    c_last_nxt  = c_last_r;
    end_row_nxt = end_row_r;
    r_nxt       = r_r;
    k_nxt       = k_r;
    bit_nxt     = bit_r;
    ctl         = '0;
    res         = '0;
    in_ready    = 1'b0;
    case (st_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          ctl.wr       = 1'b1;
          ctl.first_wr = (col_r == '0);
          col_nxt      = row_end_in ? '0 : col_r + COL_W'(1);
          if (has_emit) begin
            p_nxt       = p_first;
            p_last_nxt  = p_last;
            c_last_nxt  = col_r;
            end_row_nxt = row_end_in;
            r_nxt       = r_eff;
            k_nxt       = '0;
            st_nxt      = S_ACC;
          end
        end
      end
      S_ACC: begin
        ctl.tap_vld   = 1'b1;
        ctl.tap_first = q[SW-1];
        ctl.acc_clr   = (k_r == '0);
        if (k_r == {r_r, 1'b0}) begin
          st_nxt = S_FLUSH;
        end else begin
          k_nxt = k_r + KW'(1);
        end
      end
      S_FLUSH: begin
        bit_nxt = '1;
        st_nxt  = S_DIV;
      end
      S_DIV: begin
        ctl.div_step = 1'b1;
        ctl.div_bit  = bit_r;
        if (bit_r == '0) begin
          st_nxt = S_OUT;
        end else begin
          bit_nxt = bit_r - QB_IW'(1);
        end
      end
      S_OUT: begin
        if (merge_free) begin
          res.load    = 1'b1;
          res.row_end = end_row_r && last_pos;
          if (last_pos) begin
            st_nxt = S_IDLE;
          end else begin
            p_nxt  = p_r + COL_W'(1);
            k_nxt  = '0;
            st_nxt = S_ACC;
          end
        end
      end
      default: begin
        st_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= S_IDLE;
      col_r <= '0;
    end else begin
      st_r  <= st_nxt;
      col_r <= col_nxt;
    end
  end

  always_ff @(posedge clk) begin
    p_r       <= p_nxt;
    p_last_r  <= p_last_nxt;
    c_last_r  <= c_last_nxt;
    end_row_r <= end_row_nxt;
    r_r       <= r_nxt;
    k_r       <= k_nxt;
    bit_r     <= bit_nxt;
  end

endmodule

### rtl/rbb_merge.sv
// Merge stage: gathers the lane quotients into one output register.
module rbb_merge (
  input  logic                                         clk,
  input  logic                                         rst_n,
  input  rbb_pkg::res_ctl_t                            res,
  input  logic [rbb_pkg::NUM_LANES-1:0][rbb_pkg::PIX_W-1:0] lane_q,
  output logic                                         free,
  output logic                                         out_valid,
  input  logic                                         out_ready,
  output logic [rbb_pkg::NUM_LANES-1:0][rbb_pkg::PIX_W-1:0] out_pix,
  output logic                                         out_row_end
);
  import rbb_pkg::*;

  logic                                vld_r;
  logic [NUM_LANES-1:0][PIX_W-1:0]     pix_r;
  logic                                end_r;

  assign free = !vld_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (res.load) begin
      vld_r <= 1'b1;
    end else if (out_ready) begin
      vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res.load) begin
      pix_r <= lane_q;
      end_r <= res.row_end;
    end
  end

  assign out_valid   = vld_r;
  assign out_pix     = pix_r;
  assign out_row_end = end_r;

endmodule
